>>> rtl/core/crcg_pkg.sv
// Package with the shared constants, types and helper functions of the CRC codeword generator.
package crcg_pkg;

   // Largest supported generator degree and the widths that follow from it.
   localparam int MAX_DEGREE = 16;
   localparam int REM_W      = MAX_DEGREE;
   localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
   localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

   // Register field widths and reset values.
   localparam int CFG_DEG_W   = 5;
   localparam int CFG_COEFF_W = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CFG_DEG_W-1:0]   GEN_DEGREE_RESET     = 5'd8;
   localparam logic [CFG_COEFF_W-1:0] GEN_LOW_COEFFS_RESET = 16'd7;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GEN_DEGREE     = 1'b0,
      CSR_GEN_LOW_COEFFS = 1'b1
   } csr_index_type;

   // Effective generator settings handed to the front and the back.
   typedef struct packed {
      logic [DEG_W-1:0] degree;
      logic [REM_W-1:0] mask;
      logic [REM_W-1:0] coeffs;
   } cfg_type;

   // One queue entry: the echoed data bit and, for the final bit, the remainder.
   typedef struct packed {
      logic             data_bit;
      logic             last;
      logic [REM_W-1:0] rem;
   } qentry_type;

   // Degree zero counts as one, and anything above the maximum saturates.
   function automatic logic [DEG_W-1:0] eff_degree(input logic [CFG_DEG_W-1:0] g);
      logic [DEG_W-1:0] d;
      if (g == '0) begin
         d = DEG_W'(1);
      end else if (int'(g) > MAX_DEGREE) begin
         d = DEG_W'(MAX_DEGREE);
      end else begin
         d = DEG_W'(g);
      end
      return d;
   endfunction

   function automatic logic [REM_W-1:0] degree_mask(input logic [DEG_W-1:0] d);
      return ~({REM_W{1'b1}} << d);
   endfunction

endpackage

>>> rtl/core/crcg_req_if.sv
// Interface for the message bit channel of the CRC codeword generator.
interface crcg_req_if;
   logic valid;
   logic ready;
   logic msg_bit;
   logic msg_last;

   modport source (output valid, output msg_bit, output msg_last, input ready);
   modport sink   (input valid, input msg_bit, input msg_last, output ready);
endinterface

>>> rtl/core/crcg_rsp_if.sv
// Interface for the codeword bit channel of the CRC codeword generator.
interface crcg_rsp_if;
   logic valid;
   logic ready;
   logic code_bit;
   logic is_check;
   logic code_last;

   modport source (output valid, output code_bit, output is_check, output code_last,
                   input ready);
   modport sink   (input valid, input code_bit, input is_check, input code_last,
                   output ready);
endinterface

>>> rtl/core/crcg_front.sv
// Front end: accepts message bits, updates the running remainder and queues the work.
module crcg_front (
   input  logic                 clock,
   input  logic                 reset,
   crcg_req_if.sink             req,
   input  crcg_pkg::cfg_type    cfg,
   output logic                 push_valid,
   output crcg_pkg::qentry_type push_entry,
   input  logic                 push_ready
);
   import crcg_pkg::*;

   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] rem_in;
   logic [REM_W-1:0] rem_masked;
   logic [REM_W-1:0] rem_next;
   logic [DEG_W-1:0] top_pos;
   logic             feedback;
   logic             accept;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid & push_ready;

   // One step of bitwise long division.
   always_comb begin
      rem_masked = rem_ff & cfg.mask;
      top_pos    = cfg.degree - DEG_W'(1);
      feedback   = req.msg_bit ^ rem_masked[top_pos[IDX_W-1:0]];
      rem_next   = (rem_masked << 1) & cfg.mask;
      if (feedback) begin
         rem_next = rem_next ^ (cfg.coeffs & cfg.mask);
      end
   end

   always_comb begin
      push_entry.data_bit = req.msg_bit;
      push_entry.last     = req.msg_last;
      push_entry.rem      = rem_next;
   end

   always_comb begin
      rem_in = rem_ff;
      if (accept) begin
         rem_in = req.msg_last ? '0 : rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

endmodule

>>> rtl/core/crcg_queue.sv
// Short register queue that decouples the front end from the serializer.
module crcg_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  crcg_pkg::qentry_type          push_entry,
   output logic                          push_ready,
   output logic                          pop_valid,
   output crcg_pkg::qentry_type          pop_entry,
   input  logic                          pop,
   output logic [crcg_pkg::QCNT_W-1:0]   count
);
   import crcg_pkg::*;

   qentry_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/crcg_back.sv
// Back end: emits echoed data bits and shifts out the check bits through an output register.
module crcg_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [crcg_pkg::DEG_W-1:0] degree,
   input  logic                       pop_valid,
   input  crcg_pkg::qentry_type       pop_entry,
   output logic                       pop,
   crcg_rsp_if.source                 rsp
);
   import crcg_pkg::*;

   logic [DEG_W-1:0] cnt_ff;
   logic [DEG_W-1:0] cnt_in;
   logic [DEG_W-1:0] cnt_m1;
   logic [REM_W-1:0] shift_ff;
   logic [REM_W-1:0] shift_in;
   logic             valid_ff;
   logic             valid_in;
   logic             bit_ff;
   logic             bit_in;
   logic             check_ff;
   logic             check_in;
   logic             last_ff;
   logic             last_in;
   logic             load;

   assign rsp.valid     = valid_ff;
   assign rsp.code_bit  = bit_ff;
   assign rsp.is_check  = check_ff;
   assign rsp.code_last = last_ff;

   assign load   = !valid_ff || rsp.ready;
   assign cnt_m1 = cnt_ff - DEG_W'(1);

   // Pending check bits take priority over the next queued transaction.
   always_comb begin
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      valid_in = valid_ff;
      bit_in   = bit_ff;
      check_in = check_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         if (cnt_ff != '0) begin
            valid_in = 1'b1;
            bit_in   = shift_ff[cnt_m1[IDX_W-1:0]];
            check_in = 1'b1;
            last_in  = (cnt_ff == DEG_W'(1));
            cnt_in   = cnt_m1;
         end else if (pop_valid) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            bit_in   = pop_entry.data_bit;
            check_in = 1'b0;
            last_in  = 1'b0;
            if (pop_entry.last) begin
               shift_in = pop_entry.rem;
               cnt_in   = degree;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bit_ff   <= bit_in;
      check_ff <= check_in;
      last_ff  <= last_in;
   end

endmodule

>>> rtl/core/crc_codeword_generator.sv
// Top level of the serial CRC codeword generator with a programmable generator polynomial.
//
// Usage: message bits enter one per transaction on the req channel, most significant
// first, with msg_last set on the final bit of a message. Every bit is echoed on the
// rsp channel as a data bit (is_check low). After the final data bit the block emits
// the degree check bits of the CRC remainder, most significant first, with is_check
// high and code_last set on the last one; the remainder then restarts at zero.
// The generator degree (csr index 0) and the coefficients below the implied leading term
// (csr index 1) are written through the csr port; the user must write them only while
// the block is idle, as the block does not enforce it. An accepted bit passes through
// the queue and the output register on its way to rsp. The front end takes one bit per
// cycle while the four-entry queue has room; the serializer emits one codeword bit per
// cycle while the receiver is ready, and the req side backs up only while check bits go out.
// When the receiver stalls, the output register holds its transaction, the queue
// fills, and req.ready drops once it is full; nothing is lost.
// A synchronous reset empties the queue, clears the remainder and the output, and
// restores degree 8 with coefficients 7 (x^8 + x^2 + x + 1).
module crc_codeword_generator (
   input  logic                            clock,
   input  logic                            reset,
   crcg_req_if.sink                        req,
   crcg_rsp_if.source                      rsp,
   input  logic                            csr_wr_en,
   input  logic [crcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crcg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import crcg_pkg::*;

   logic [CFG_DEG_W-1:0]   gen_degree_ff;
   logic [CFG_DEG_W-1:0]   gen_degree_in;
   logic [CFG_COEFF_W-1:0] gen_low_coeffs_ff;
   logic [CFG_COEFF_W-1:0] gen_low_coeffs_in;
   cfg_type                cfg;
   logic                   push_valid;
   qentry_type             push_entry;
   logic                   push_ready;
   logic                   pop_valid;
   qentry_type             pop_entry;
   logic                   pop;
   logic [QCNT_W-1:0]      q_count;

   // Configuration registers; both are plain write-only registers.
   always_comb begin
      gen_degree_in     = gen_degree_ff;
      gen_low_coeffs_in = gen_low_coeffs_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GEN_DEGREE: begin
               gen_degree_in = csr_wdata[CFG_DEG_W-1:0];
            end
            CSR_GEN_LOW_COEFFS: begin
               gen_low_coeffs_in = csr_wdata[CFG_COEFF_W-1:0];
            end
            default: begin
               gen_degree_in = gen_degree_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_degree_ff     <= GEN_DEGREE_RESET;
         gen_low_coeffs_ff <= GEN_LOW_COEFFS_RESET;
      end else begin
         gen_degree_ff     <= gen_degree_in;
         gen_low_coeffs_ff <= gen_low_coeffs_in;
      end
   end

   // The effective degree is shared by both halves of the datapath; the mask and coefficients go to the front end only.
   always_comb begin
      cfg.degree = eff_degree(gen_degree_ff);
      cfg.mask   = degree_mask(cfg.degree);
      cfg.coeffs = REM_W'(gen_low_coeffs_ff);
   end

   crcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   crcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .count      (q_count)
   );

   crcg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .degree    (cfg.degree),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp       (rsp)
   );

   // The queue never holds more transactions than it has slots.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   // A full queue must hold off the front end.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !req.ready)
      else $error("front end ready while the queue is full");

   // The end-of-codeword marker only ever rides on a check bit.
   a_last_is_check: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.code_last) |-> rsp.is_check)
      else $error("code_last on a data bit");

   // An accepted bit lands in the queue on the next edge.
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !pop) |=> (q_count == $past(q_count) + QCNT_W'(1)))
      else $error("accepted transaction not queued");

endmodule

>>> tb/crc_codeword_checker.sv
// Checker that predicts the codeword bit stream of the CRC codeword generator and compares it.
module crc_codeword_checker (
   input  logic                            clock,
   input  logic                            reset,
   crcg_req_if                             req,
   crcg_rsp_if                             rsp,
   input  logic                            csr_wr_en,
   input  logic [crcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crcg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              pending_bits
);
   import crcg_pkg::*;

   typedef struct packed {
      logic code_bit;
      logic is_check;
      logic code_last;
   } codeword_bit_type;

   codeword_bit_type       codeword_q[$];
   logic [CFG_DEG_W-1:0]   degree_reg;
   logic [CFG_COEFF_W-1:0] coeff_reg;
   logic [REM_W-1:0]       crc_rem;
   int                     errors = 0;

   // Shifts one message bit through the long division and queues the codeword bits it yields.
   task automatic divide_bit(input logic msg_bit, input logic msg_last);
      int               d;
      logic [REM_W-1:0] mask;
      logic [REM_W-1:0] r;
      logic             fb;
      d = (degree_reg == '0) ? 1 :
          ((int'(degree_reg) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_reg));
      mask = REM_W'((64'd1 << d) - 64'd1);
      r = crc_rem & mask;
      fb = msg_bit ^ r[d-1];
      r = (r << 1) & mask;
      if (fb) begin
         r = r ^ (coeff_reg & mask);
      end
      crc_rem = r;
      codeword_q.push_back('{code_bit: msg_bit, is_check: 1'b0, code_last: 1'b0});
      if (msg_last) begin
         for (int i = d - 1; i >= 0; i--) begin
            codeword_q.push_back('{code_bit: r[i], is_check: 1'b1, code_last: (i == 0)});
         end
         crc_rem = '0;
      end
   endtask

   task automatic report_error(input codeword_bit_type want, input codeword_bit_type seen,
                               input bit unexpected);
      errors++;
      if (errors <= 10) begin
         if (unexpected) begin
            $display("%0t: codeword bit %b (check %b, last %b) arrived with none expected",
                     $time, seen.code_bit, seen.is_check, seen.code_last);
         end else begin
            $display("%0t: codeword bit mismatch: expected bit %b check %b last %b, got %b %b %b",
                     $time, want.code_bit, want.is_check, want.code_last,
                     seen.code_bit, seen.is_check, seen.code_last);
         end
      end
   endtask

   always @(posedge clock) begin
      codeword_bit_type seen;
      codeword_bit_type want;
      if (reset) begin
         codeword_q.delete();
         degree_reg = GEN_DEGREE_RESET;
         coeff_reg  = GEN_LOW_COEFFS_RESET;
         crc_rem    = '0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GEN_DEGREE) begin
               degree_reg = csr_wdata[CFG_DEG_W-1:0];
            end else if (csr_index == CSR_GEN_LOW_COEFFS) begin
               coeff_reg = csr_wdata[CFG_COEFF_W-1:0];
            end
         end
         if (req.valid && req.ready) begin
            divide_bit(req.msg_bit, req.msg_last);
         end
         if (rsp.valid && rsp.ready) begin
            seen = '{code_bit: rsp.code_bit, is_check: rsp.is_check, code_last: rsp.code_last};
            if (codeword_q.size() == 0) begin
               report_error('0, seen, 1'b1);
            end else begin
               want = codeword_q.pop_front();
               if (seen !== want) begin
                  report_error(want, seen, 1'b0);
               end
            end
         end
      end
      pending_bits   <= codeword_q.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/testbench.sv
// Top of the CRC codeword generator testbench: clock, reset, stimulus and the final verdict.
module testbench;
   import crcg_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  idle_bursts;
   int                    mismatch_count;
   int                    pending_bits;

   crcg_req_if req_if ();
   crcg_rsp_if rsp_if ();

   // The clock period is four time units.
   always #2 clock = ~clock;

   crc_codeword_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The checker watches both channels and the register port, predicts every codeword bit
   // and reports back how many mismatches it has seen and how many bits are still due.
   crc_codeword_checker codeword_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_bits   (pending_bits)
   );

   // Presents one message bit and holds it until the block accepts the transaction. While
   // idle bursts are enabled, valid sometimes drops beforehand.
   task automatic send_bit(input logic msg_bit, input logic msg_last);
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.msg_bit  <= msg_bit;
      req_if.msg_last <= msg_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stops sending and waits until every predicted codeword bit has come out, plus a margin
   // for the pipeline.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_bits != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both generator registers on back-to-back cycles. The bits of the data word above
   // the degree field are random, since the block must ignore them.
   task automatic program_generator(input logic [CFG_DEG_W-1:0]   degree,
                                    input logic [CFG_COEFF_W-1:0] coeffs);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GEN_DEGREE;
      csr_wdata <= {(CSR_DATA_W - CFG_DEG_W)'($urandom), degree};
      @(posedge clock);
      csr_index <= CSR_GEN_LOW_COEFFS;
      csr_wdata <= coeffs;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Degrees favor the useful range but regularly hit zero, one, the maximum and values
   // beyond it that must saturate.
   function automatic logic [CFG_DEG_W-1:0] pick_degree();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CFG_DEG_W'(1);
         2:       return CFG_DEG_W'(MAX_DEGREE);
         3:       return CFG_DEG_W'($urandom_range(MAX_DEGREE + 1, 31));
         default: return CFG_DEG_W'($urandom_range(2, MAX_DEGREE - 1));
      endcase
   endfunction

   function automatic logic [CFG_COEFF_W-1:0] pick_coeffs();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return CFG_COEFF_W'($urandom);
      endcase
   endfunction

   // The receiver stalls in bursts while idle bursts are enabled.
   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_bursts && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int msg_left;
      int n;
      req_if.valid    <= 1'b0;
      req_if.msg_bit  <= 1'b0;
      req_if.msg_last <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_GEN_DEGREE;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      idle_bursts     = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The reset generator (degree 8, x^8 + x^2 + x + 1) comes first, with
      // a message whose first bit is zero so that the remainder must start out cleared.
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      wait_for_drain();

      // A degree of zero behaves as degree one, and all coefficient bits at or above the
      // effective degree are dropped. Single-bit messages exercise back-to-back codewords.
      program_generator('0, '1);
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b1);
      wait_for_drain();

      // Plain parity: degree one with coefficient one.
      program_generator(CFG_DEG_W'(1), CFG_COEFF_W'(1));
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b1);
      wait_for_drain();

      // Full sixteen-bit generator, then a degree change in the middle of a message, which
      // truncates the running remainder to the new degree.
      program_generator(CFG_DEG_W'(MAX_DEGREE), 16'h1021);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      wait_for_drain();
      program_generator(CFG_DEG_W'(4), 16'h0013);
      send_bit(1'b1, 1'b1);
      wait_for_drain();

      // Degrees above the maximum saturate to it, including the largest writable value.
      program_generator(CFG_DEG_W'(MAX_DEGREE + 1), 16'h8005);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b1);
      wait_for_drain();
      program_generator('1, '0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b1);
      wait_for_drain();

      // Random part: messages of random length and content under random generators. The
      // generator changes every forty bits, wherever that falls inside a message, and once
      // the sender simply waits for the pipeline to empty. Idling stops near the end.
      program_generator(pick_degree(), pick_coeffs());
      msg_left = 0;
      n = 0;
      while (n < 250 || msg_left > 0) begin
         if (n > 0 && n % 40 == 0) begin
            wait_for_drain();
            program_generator(pick_degree(), pick_coeffs());
         end else if (n == 125) begin
            wait_for_drain();
         end
         if (n == 200) begin
            idle_bursts = 1'b0;
         end
         if (msg_left == 0) begin
            msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
         end
         send_bit(1'($urandom), msg_left == 1);
         msg_left--;
         n++;
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_bits == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
